// File: src/lrkd_pkg.sv
// ----------------------------------------------------------------------------
// lrkd_pkg: shared types and constants
// Sizes, payload words and the controller/datapath command and status words
// of the longest-run tracker.
// ----------------------------------------------------------------------------
package lrkd_pkg;

  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned SYM_COUNT   = 1 << SYMBOL_BITS;
  localparam int unsigned PTR_W       = $clog2(MAX_LEN);
  localparam int unsigned LEN_W       = $clog2(MAX_LEN + 1);
  localparam int unsigned LIMIT_W     = 9;
  localparam int unsigned DIST_W      = $clog2(SYM_COUNT + 1);

  localparam logic [LIMIT_W-1:0] MAX_DISTINCT_RST = LIMIT_W'(2);

  typedef struct packed {
    logic [7:0] symbol;
    logic       start_req;
  } in_word_t;

  typedef struct packed {
    logic [10:0] best_length;
    logic [10:0] window_length;
    logic [9:0]  window_start;
    logic        overflow;
  } out_word_t;

  typedef struct packed {
    logic load;         // take the input word, begin a new sequence on start
    logic hist_rd;      // read history at the window start
    logic cnt_rd_tail;  // read the count of the oldest symbol
    logic cnt_rd_new;   // read the count of the new symbol
    logic drop;         // drop the oldest symbol
    logic insert;       // insert the new symbol
    logic emit;         // load the result register
  } cmd_t;

  typedef struct packed {
    logic full;         // window holds MAX_LEN symbols
    logic over;         // too many distinct values and more than one symbol
  } status_t;

endpackage

// File: src/lrkd_ctrl.sv
// ----------------------------------------------------------------------------
// lrkd_ctrl: sequencing state machine
// Steps each word through the full-ring drop, insert, shrink loop and emit.
// ----------------------------------------------------------------------------
module lrkd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  lrkd_pkg::status_t status_i,
  output lrkd_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FULL,
    ST_DROP_CNT,
    ST_DROP_WR,
    ST_INS_CNT,
    ST_INS_WR,
    ST_SHRINK,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   shrink_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:     cmd_o.load        = in_valid_i;
      ST_CHK_FULL: cmd_o.hist_rd     = 1'b1;
      ST_DROP_CNT: cmd_o.cnt_rd_tail = 1'b1;
      ST_DROP_WR:  cmd_o.drop        = 1'b1;
      ST_INS_CNT:  cmd_o.cnt_rd_new  = 1'b1;
      ST_INS_WR:   cmd_o.insert      = 1'b1;
      ST_SHRINK:   cmd_o.hist_rd     = 1'b1;
      ST_EMIT:     cmd_o.emit        = !out_valid_q || out_ready_i;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      shrink_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CHK_FULL;
          end
        end
        ST_CHK_FULL: begin
          shrink_q <= 1'b0;
          state_q  <= status_i.full ? ST_DROP_CNT : ST_INS_CNT;
        end
        ST_DROP_CNT: state_q <= ST_DROP_WR;
        ST_DROP_WR:  state_q <= shrink_q ? ST_SHRINK : ST_INS_CNT;
        ST_INS_CNT:  state_q <= ST_INS_WR;
        ST_INS_WR: begin
          shrink_q <= 1'b1;
          state_q  <= ST_SHRINK;
        end
        ST_SHRINK:   state_q <= status_i.over ? ST_DROP_CNT : ST_EMIT;
        ST_EMIT: begin
          if (cmd_o.emit) begin
            state_q <= ST_IDLE;
          end
        end
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/lrkd_dpath.sv
// ----------------------------------------------------------------------------
// lrkd_dpath: window datapath
// History ring, symbol count table, window pointers and the result register.
// ----------------------------------------------------------------------------
module lrkd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lrkd_pkg::LIMIT_W-1:0]        cfg_data_i,
  input  lrkd_pkg::in_word_t                  in_data_i,
  input  lrkd_pkg::cmd_t                      cmd_i,
  output lrkd_pkg::status_t                   status_o,
  output lrkd_pkg::out_word_t                 out_data_o
);

  localparam int unsigned SB = lrkd_pkg::SYMBOL_BITS;
  localparam int unsigned PW = lrkd_pkg::PTR_W;
  localparam int unsigned LW = lrkd_pkg::LEN_W;
  localparam int unsigned DW = lrkd_pkg::DIST_W;
  localparam int unsigned KW = lrkd_pkg::LIMIT_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(lrkd_pkg::MAX_LEN - 1);
  localparam logic [LW-1:0] LEN_MAX  = LW'(lrkd_pkg::MAX_LEN);

  logic [SB-1:0] hist_mem [lrkd_pkg::MAX_LEN];
  logic [LW-1:0] cnt_mem  [lrkd_pkg::SYM_COUNT];

  logic [lrkd_pkg::SYM_COUNT-1:0] vld_q;
  logic [KW-1:0] max_q;
  logic [DW-1:0] distinct_q;
  logic [PW-1:0] head_q, tail_q;
  logic [LW-1:0] win_q, seq_q, best_q;
  logic          ovf_q;

  logic [SB-1:0] sym_q;
  logic [SB-1:0] hist_rdata_q;
  logic [LW-1:0] cnt_rdata_q;
  logic          cnt_rvld_q;
  logic [SB-1:0] cnt_waddr_q;
  lrkd_pkg::out_word_t out_q;

  logic [SB-1:0] cnt_raddr;
  logic [LW-1:0] cnt_cur;
  logic [KW-1:0] limit;
  logic [LW-1:0] best_nxt;
  logic [PW-1:0] tail_inc, head_inc;

  assign cnt_raddr = cmd_i.cnt_rd_tail ? hist_rdata_q : sym_q;
  assign cnt_cur   = cnt_rvld_q ? cnt_rdata_q : '0;
  assign limit     = (max_q == '0) ? KW'(1) : max_q;
  assign best_nxt  = (win_q > best_q) ? win_q : best_q;
  assign tail_inc  = (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
  assign head_inc  = (head_q == PTR_LAST) ? '0 : head_q + PW'(1);

  assign status_o.full = (win_q >= LEN_MAX);
  assign status_o.over = (KW'(distinct_q) > limit) && (win_q > LW'(1));
  assign out_data_o    = out_q;

  // history ring: read at the window start, write at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_rd) begin
      hist_rdata_q <= hist_mem[tail_q];
    end
    if (cmd_i.insert) begin
      hist_mem[head_q] <= sym_q;
    end
  end

  // count table; an entry without its valid bit reads as zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_rd_tail || cmd_i.cnt_rd_new) begin
      cnt_rdata_q <= cnt_mem[cnt_raddr];
      cnt_rvld_q  <= vld_q[cnt_raddr];
      cnt_waddr_q <= cnt_raddr;
    end
    if (cmd_i.drop && (cnt_cur != '0)) begin
      cnt_mem[cnt_waddr_q] <= cnt_cur - LW'(1);
    end else if (cmd_i.insert) begin
      cnt_mem[cnt_waddr_q] <= cnt_cur + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q <= in_data_i.symbol[SB-1:0];
    end
    if (cmd_i.emit) begin
      out_q.best_length   <= 11'(best_nxt);
      out_q.window_length <= 11'(win_q);
      out_q.window_start  <= 10'(tail_q);
      out_q.overflow      <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q      <= lrkd_pkg::MAX_DISTINCT_RST;
      vld_q      <= '0;
      distinct_q <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      win_q      <= '0;
      seq_q      <= '0;
      best_q     <= '0;
      ovf_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (in_data_i.start_req) begin
          vld_q      <= '0;
          distinct_q <= '0;
          head_q     <= '0;
          tail_q     <= '0;
          win_q      <= '0;
          best_q     <= '0;
          seq_q      <= LW'(1);
          ovf_q      <= 1'b0;
        end else if (seq_q >= LEN_MAX) begin
          ovf_q <= 1'b1;
        end else begin
          seq_q <= seq_q + LW'(1);
        end
      end
      if (cmd_i.drop) begin
        if (cnt_cur != '0) begin
          vld_q[cnt_waddr_q] <= 1'b1;
          if ((cnt_cur == LW'(1)) && (distinct_q != '0)) begin
            distinct_q <= distinct_q - DW'(1);
          end
        end
        tail_q <= tail_inc;
        win_q  <= win_q - LW'(1);
      end
      if (cmd_i.insert) begin
        vld_q[cnt_waddr_q] <= 1'b1;
        if (cnt_cur == '0) begin
          distinct_q <= distinct_q + DW'(1);
        end
        head_q <= head_inc;
        win_q  <= win_q + LW'(1);
      end
      if (cmd_i.emit) begin
        best_q <= best_nxt;
      end
    end
  end

endmodule

// File: src/longest_run_k_distinct_unit.sv
// Flow: an accepted word passes the full check, a drop (count read, write) when the
//   ring is full on arrival, insert (count read, write), then a shrink check with a
//   further drop per symbol shrunk, then waits until the previous result is taken.
// A new word is accepted only once the last result is loaded into the output register;
//   the history ring and count table are single-port, one access per step.
// Reset (rst_ni low, asynchronous): empty sequence, counts zero, max_distinct 2.
// ----------------------------------------------------------------------------
// longest_run_k_distinct_unit: longest run with at most k distinct symbols
// Sliding-window tracker over a symbol stream, reporting best and current
// window after every word. History contents are undefined after reset; only
// written entries are read.
// ----------------------------------------------------------------------------
module longest_run_k_distinct_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lrkd_pkg::LIMIT_W-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lrkd_pkg::in_word_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lrkd_pkg::out_word_t           out_data_o
);

  lrkd_pkg::cmd_t    cmd;
  lrkd_pkg::status_t status;

  // The limit register takes a word at any time; write it only while no word
  // is in flight.
  assign cfg_ready_o = 1'b1;

  // Controller: walks each word through drop-if-full, insert, shrink and emit,
  // holding the finished result in the output register until it is taken.
  lrkd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: history ring, count table with valid bits, window pointers.
  lrkd_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// File: verif/longest_run_k_distinct_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// longest_run_k_distinct_unit_tb: self-checking bench for the longest-run unit
// Streams symbol words through the tracker under several distinct-value
// limits, predicts every result word and checks them in order, with random
// back-pressure and gaps on both channels.
// ----------------------------------------------------------------------------
module longest_run_k_distinct_unit_tb;

  localparam int unsigned STALL_CYCLES = 300;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 40;      // settle time once idle
  localparam int unsigned TIMEOUT_NS   = 3000000;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // --------------------------------------------------------------------------
  logic                         clk_i     = 1'b0;
  logic                         rst_ni    = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [lrkd_pkg::LIMIT_W-1:0] cfg_data  = '0;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  lrkd_pkg::in_word_t           in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  lrkd_pkg::out_word_t          out_data;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longest_run_k_distinct_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // --------------------------------------------------------------------------
  // Bench state: words waiting to be sent, predicted results, idling knobs
  // --------------------------------------------------------------------------
  lrkd_pkg::in_word_t  pending_words[$];
  lrkd_pkg::out_word_t expected_runs[$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned error_count = 0;
  logic        hold_req    = 1'b0;
  logic        hold_done   = 1'b0;
  int unsigned hold_left   = 0;

  // --------------------------------------------------------------------------
  // Window predictor: its own copy of the ring, the tallies and the limit
  // --------------------------------------------------------------------------
  logic [7:0]                   ring_syms [lrkd_pkg::MAX_LEN];
  logic [10:0]                  sym_tally [lrkd_pkg::SYM_COUNT];
  logic [8:0]                   distinct_now;
  logic [lrkd_pkg::PTR_W-1:0]   ring_head;
  logic [lrkd_pkg::PTR_W-1:0]   ring_tail;
  logic [10:0]                  span_len;
  logic [10:0]                  seq_seen;
  logic [10:0]                  best_span;
  logic                         seq_overflow;
  logic [lrkd_pkg::LIMIT_W-1:0] allowed_distinct;

  function automatic void restart_run();
    for (int i = 0; i < lrkd_pkg::SYM_COUNT; i++) sym_tally[i] = '0;
    distinct_now = '0;
    ring_head    = '0;
    ring_tail    = '0;
    span_len     = '0;
    seq_seen     = '0;
    best_span    = '0;
    seq_overflow = 1'b0;
  endfunction

  // Drop the oldest symbol of the window; its value leaves the distinct set
  // when its tally reaches zero.
  function automatic void retire_oldest();
    logic [7:0] s;
    s = ring_syms[ring_tail];
    if (sym_tally[s] != 0) begin
      sym_tally[s] = sym_tally[s] - 1'b1;
      if (sym_tally[s] == 0 && distinct_now != 0) distinct_now = distinct_now - 1'b1;
    end
    ring_tail = ring_tail + 1'b1;
    span_len  = span_len - 1'b1;
  endfunction

  // Take one symbol word and return the result word it produces.
  function automatic lrkd_pkg::out_word_t advance_window(lrkd_pkg::in_word_t w);
    logic [8:0]          cap;
    lrkd_pkg::out_word_t r;
    // a limit of zero still keeps the newest symbol
    cap = (allowed_distinct == 0) ? 9'd1 : allowed_distinct;
    if (w.start_req) restart_run();
    // past MAX_LEN symbols flag overflow and stop counting
    if (seq_seen >= lrkd_pkg::MAX_LEN) seq_overflow = 1'b1;
    else seq_seen = seq_seen + 1'b1;
    // full ring: make room before writing
    if (span_len >= lrkd_pkg::MAX_LEN) retire_oldest();
    ring_syms[ring_head] = w.symbol;
    ring_head            = ring_head + 1'b1;
    span_len             = span_len + 1'b1;
    sym_tally[w.symbol]  = sym_tally[w.symbol] + 1'b1;
    if (sym_tally[w.symbol] == 1) distinct_now = distinct_now + 1'b1;
    while (distinct_now > cap && span_len > 1) retire_oldest();
    if (span_len > best_span) best_span = span_len;
    r.best_length   = best_span;
    r.window_length = span_len;
    r.window_start  = ring_tail;
    r.overflow      = seq_overflow;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------
  function automatic string fmt_word(lrkd_pkg::out_word_t w);
    return $sformatf("best=%0d len=%0d start=%0d ovf=%0b",
                     w.best_length, w.window_length, w.window_start, w.overflow);
  endfunction

  // Count every error; show only the first ten.
  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued words, hold each until accepted, predict on accept
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_runs.push_back(advance_window(in_data));
      // pick the next word only once the current one has gone
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: one stretch of STALL_CYCLES with the receiver blocked
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= STALL_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: random back-pressure, fully blocked during the hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result word with the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    lrkd_pkg::out_word_t want;
    string               diff;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_runs.size() == 0) begin
        note_error({"result word with none expected: ", fmt_word(out_data)});
      end else begin
        want = expected_runs.pop_front();
        diff = "";
        if (out_data.best_length !== want.best_length) diff = {diff, " best_length"};
        if (out_data.window_length !== want.window_length) diff = {diff, " window_length"};
        if (out_data.window_start !== want.window_start) diff = {diff, " window_start"};
        if (out_data.overflow !== want.overflow) diff = {diff, " overflow"};
        if (diff != "") begin
          note_error({"mismatch in", diff, ": expected ", fmt_word(want),
                      ", got ", fmt_word(out_data)});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] sym, input logic start);
    lrkd_pkg::in_word_t w;
    w.symbol    = sym;
    w.start_req = start;
    pending_words.push_back(w);
  endtask

  // Wait until every queued word is sent and every result is back, then
  // let the block go quiet. Sample on the falling edge, clear of the updates.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid || expected_runs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the limit register; only called with the block idle.
  task automatic write_limit(input logic [lrkd_pkg::LIMIT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid        <= 1'b0;
    allowed_distinct = value;
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Queue random sequences: mostly a start word followed by symbols from a
  // narrow alphabet, so that windows grow and shrink; some noise symbols from
  // the full range and some sequences that simply carry on without a start.
  task automatic queue_sequences(input int unsigned n_words);
    int unsigned queued;
    int unsigned seq_len;
    int unsigned alpha;
    logic [7:0]  base;
    logic        open_new;
    logic [7:0]  sym;
    queued = 0;
    @(negedge clk_i);
    while (queued < n_words) begin
      seq_len  = $urandom_range(60, 1);
      if (seq_len > n_words - queued) seq_len = n_words - queued;
      alpha    = $urandom_range(12, 1);
      base     = 8'($urandom_range(255, 0));
      open_new = ($urandom_range(9, 0) != 0);
      for (int i = 0; i < seq_len; i++) begin
        if ($urandom_range(9, 0) == 0) sym = 8'($urandom_range(255, 0));
        else sym = 8'(base + $urandom_range(alpha - 1, 0));
        // the odd stray start flag cuts a sequence short
        push_word(sym, (open_new && i == 0) || ($urandom_range(99, 0) == 0));
      end
      queued += seq_len;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < lrkd_pkg::MAX_LEN; i++) ring_syms[i] = '0;
    restart_run();
    allowed_distinct = lrkd_pkg::MAX_DISTINCT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset limit of two; leading words carry no start flag and so continue
    // the sequence opened by reset. Symbol extremes and repeats.
    set_idling(6, 75);
    push_word(8'd0, 1'b0);
    push_word(8'd255, 1'b0);
    push_word(8'd0, 1'b0);
    push_word(8'd255, 1'b0);
    push_word(8'd1, 1'b0);
    push_word(8'd1, 1'b0);
    push_word(8'd170, 1'b0);
    push_word(8'd85, 1'b0);
    push_word(8'd85, 1'b0);
    push_word(8'd3, 1'b1);
    push_word(8'd3, 1'b0);
    push_word(8'd3, 1'b0);
    push_word(8'd200, 1'b0);
    push_word(8'd7, 1'b0);
    settle();

    // Limit of zero behaves as one
    write_limit('0);
    @(negedge clk_i);
    push_word(8'd9, 1'b1);
    push_word(8'd9, 1'b0);
    push_word(8'd10, 1'b0);
    push_word(8'd10, 1'b0);
    push_word(8'd10, 1'b0);
    push_word(8'd9, 1'b0);
    settle();

    write_limit(9'd1);
    queue_sequences(60);
    settle();

    // All-ones limit never forces a drop: one sequence keeps growing, then a
    // fresh start clears it.
    set_idling(75, 6);
    write_limit('1);
    @(negedge clk_i);
    push_word(8'($urandom_range(255, 0)), 1'b1);
    for (int i = 0; i < 60; i++) push_word(8'($urandom_range(255, 0)), 1'b0);
    push_word(8'd42, 1'b1);
    push_word(8'd43, 1'b0);
    settle();

    write_limit(9'd256);
    queue_sequences(60);
    settle();

    write_limit(9'd3);
    queue_sequences(60);
    settle();

    // No idling, with one long receiver hold-off while words keep coming
    set_idling(0, 0);
    write_limit(lrkd_pkg::LIMIT_W'($urandom_range(256, 1)));
    @(posedge clk_i);
    hold_req <= 1'b1;
    queue_sequences(70);
    settle();

    write_limit(lrkd_pkg::LIMIT_W'($urandom_range(511, 0)));
    queue_sequences(70);
    settle();

    if (error_count == 0) begin
      $display("longest_run_k_distinct_unit_tb passed");
    end else begin
      $display("longest_run_k_distinct_unit_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("longest_run_k_distinct_unit_tb failed");
    $finish;
  end

endmodule

// File: longest_run_k_distinct_unit.f
src/lrkd_pkg.sv
src/lrkd_ctrl.sv
src/lrkd_dpath.sv
src/longest_run_k_distinct_unit.sv
verif/longest_run_k_distinct_unit_tb.sv
